FILE: src/tkr_pkg.sv
// Shared types, command codes and defaults for the top-k RSSI insertion list.
// No dependencies; every module of the block imports this package.
package tkr_pkg;

    // default number of list slots
    localparam int SLOTS_DEF = 6;

    // command codes of an input word
    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_REPORT = 2'd2;

    // input word
    typedef struct packed {
        logic [1:0]        command;
        logic signed [7:0] strength;
        logic [47:0]       station_id;
        logic [3:0]        radio_channel;
    } t_in_word;

    // output word, one per emitted entry
    typedef struct packed {
        logic [2:0]        rank;
        logic signed [7:0] ranked_strength;
        logic [47:0]       ranked_station;
        logic [3:0]        ranked_channel;
        logic              last_entry;
    } t_out_word;

    // one list slot
    typedef struct packed {
        logic signed [7:0] strength;
        logic [47:0]       station;
        logic [3:0]        channel;
    } t_slot;

    // controller commands to the datapath
    typedef struct packed {
        logic clear;
        logic insert;
        logic scan_start;
        logic scan_step;
        logic load_out;
    } t_dp_cmd;

    // datapath status to the controller
    typedef struct packed {
        logic scan_hit;
        logic scan_end;
    } t_dp_stat;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

endpackage

FILE: src/top_k_rssi_insertion_list_core.sv
// Top level of the top-k RSSI insertion list: controller plus slot datapath.
// Depends on tkr_pkg, tkr_ctrl and tkr_slot_array.
//
// Start and insert words are accepted in idle and can be sent back to back: the
// insert compares the report against every slot at once and shifts the chain
// of slot cells in the same cycle. A report word walks the slot index counter
// from slot 0 to slot SLOTS-1, one slot per cycle while the output side does
// not stall, and holds the input stalled until the scan has ended; empty slots
// are skipped without producing a word and the final emitted word carries
// last_entry. The output register lets the next command be accepted while the
// final word of a report still waits to be taken.
module top_k_rssi_insertion_list_core
    import tkr_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    tkr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_in_word.command),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    tkr_slot_array #(
        .SLOTS (SLOTS)
    ) u_slots (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_word  (i_in_word),
        .o_stat     (w_stat),
        .o_out_word (o_out_word)
    );

endmodule

FILE: src/tkr_slot_array.sv
// Datapath: sorted slot cells with compare-and-shift insert, report scan
// counter and output word register. Depends on tkr_pkg.
module tkr_slot_array
    import tkr_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    input  t_in_word  i_in_word,
    output t_dp_stat  o_stat,
    output t_out_word o_out_word
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_slot            r_slot [SLOTS];
    t_slot            n_slot [SLOTS];
    t_slot            v_src  [SLOTS];
    logic [SLOTS-1:0] v_empty;
    logic [SLOTS-1:0] v_hit;
    logic [SLOTS-1:0] v_shift;
    logic             v_pre_stop;
    logic             v_pre_gt;
    logic             v_stop;
    t_slot            v_new;
    logic [IW-1:0]    r_idx;
    logic [IW-1:0]    n_idx;
    logic [SLOTS-1:0] v_above;
    t_out_word        r_out;
    t_out_word        n_out;

    // incoming entry
    assign v_new.strength = i_in_word.strength;
    assign v_new.station  = i_in_word.station_id;
    assign v_new.channel  = i_in_word.radio_channel;

    // shift source: each cell takes the one above it, cell 0 never shifts
    for (genvar g = 0; g < SLOTS; g++) begin : g_src
        if (g == 0) begin : g_top
            assign v_src[g] = '0;
        end else begin : g_rest
            assign v_src[g] = r_slot[g-1];
        end
        assign v_empty[g] = (r_slot[g].strength == 8'sd0);
    end

    // find the insert point: first empty slot or first strictly weaker entry
    always_comb begin
        v_pre_stop = 1'b0;
        v_pre_gt   = 1'b0;
        v_stop     = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            v_stop     = v_empty[i] || (i_in_word.strength > r_slot[i].strength);
            v_hit[i]   = v_stop && !v_pre_stop;
            v_shift[i] = v_pre_gt;
            v_pre_gt   = v_pre_gt || (v_hit[i] && !v_empty[i]);
            v_pre_stop = v_pre_stop || v_stop;
        end
    end

    // next slot contents
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            n_slot[i] = r_slot[i];
            if (i_cmd.clear) begin
                n_slot[i] = '0;
            end else if (i_cmd.insert) begin
                if (v_hit[i]) begin
                    n_slot[i] = v_new;
                end else if (v_shift[i]) begin
                    n_slot[i] = v_src[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SLOTS; i++) begin
            if (!i_rst_n) begin
                r_slot[i] <= '0;
            end else begin
                r_slot[i] <= n_slot[i];
            end
        end
    end

    // report scan counter
    always_comb begin
        n_idx = r_idx;
        if (i_cmd.scan_start) begin
            n_idx = '0;
        end else if (i_cmd.scan_step && (r_idx != IW'(SLOTS - 1))) begin
            n_idx = r_idx + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

    // status and last-entry detect: no filled slot below the current one
    assign v_above         = ~v_empty >> r_idx;
    assign o_stat.scan_hit = !v_empty[r_idx];
    assign o_stat.scan_end = (r_idx == IW'(SLOTS - 1));

    // output word register
    always_comb begin
        n_out = r_out;
        if (i_cmd.load_out) begin
            n_out.rank            = 3'({1'b0, r_idx} + (IW + 1)'(1));
            n_out.ranked_strength = r_slot[r_idx].strength;
            n_out.ranked_station  = r_slot[r_idx].station;
            n_out.ranked_channel  = r_slot[r_idx].channel;
            n_out.last_entry      = ((v_above >> 1) == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_word = r_out;

endmodule

FILE: src/tkr_ctrl.sv
// Controller: accepts commands, sequences the report scan and owns the
// output valid flag. Depends on tkr_pkg.
module tkr_ctrl
    import tkr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_command,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_ov;
    logic   n_ov;
    logic   v_take;
    logic   v_out_free;

    assign v_take     = i_in_valid && (r_state == ST_IDLE);
    assign v_out_free = !r_ov || !i_out_stall;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (v_take) begin
                    o_cmd.clear      = (i_command == CMD_START);
                    o_cmd.insert     = (i_command == CMD_INSERT);
                    o_cmd.scan_start = (i_command == CMD_REPORT);
                    if (i_command == CMD_REPORT) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (v_out_free) begin
                    o_cmd.scan_step = 1'b1;
                    o_cmd.load_out  = i_stat.scan_hit;
                    if (i_stat.scan_end) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        n_ov = r_ov;
        if (o_cmd.load_out) begin
            n_ov = 1'b1;
        end else if (!i_out_stall) begin
            n_ov = 1'b0;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_ov;

    // a held word is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_out_stall) |-> !o_cmd.load_out)
        else $error("output word overwritten while stalled");

    // a new word appears only from the scan
    a_rise_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> ($past(r_state) == ST_EMIT))
        else $error("output valid outside report scan");

    // an accepted report starts the scan
    a_report_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v_take && (i_command == CMD_REPORT)) |=> (r_state == ST_EMIT))
        else $error("report did not start scan");

    // the scan leaves only at its final slot
    a_scan_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EMIT) && (n_state == ST_IDLE)) |-> i_stat.scan_end)
        else $error("scan ended early");

endmodule
